// ----- rtl/core/rpw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpw_pkg
// Shared types and constants for the response pattern waiter.
// ----------------------------------------------------------------------------
package rpw_pkg;

    // Command codes of an input transaction. Code 3 carries no meaning.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Outcome codes of a result transaction.
    localparam logic [1:0] OUT_MATCHED = 2'd0;
    localparam logic [1:0] OUT_LENGTH  = 2'd1;
    localparam logic [1:0] OUT_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd4;

    // Reset values: the pattern is "+IPD," and the timeout limit is counted in ticks.
    localparam logic [63:0] PATTERN_LOW_RST    = 64'd190124673323;
    localparam logic [63:0] PATTERN_HIGH_RST   = 64'd0;
    localparam logic [4:0]  PATTERN_LENGTH_RST = 5'd5;
    localparam logic        LENGTH_MODE_RST    = 1'b1;
    localparam logic [15:0] TIMEOUT_TICKS_RST  = 16'd600;

    localparam logic [7:0]  FIELD_END = 8'h3A;
    localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [16:0] MAG_LIMIT = 17'd32768;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MATCH,
        PH_FIELD
    } phase_t;

    typedef enum logic [1:0] {
        ST_SPACE,
        ST_DIGITS,
        ST_DONE
    } stage_t;

    typedef struct packed {
        logic [127:0] pattern;
        logic [4:0]   pattern_length;
        logic         length_mode;
        logic [15:0]  timeout_ticks;
    } cfg_t;

    typedef struct packed {
        stage_t      stage;
        logic        negative;
        logic [16:0] acc;
    } num_state_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  outcome;
        logic [15:0] length_value;
    } result_t;

endpackage

// ----- rtl/core/response_pattern_waiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_pattern_waiter
// Arms on a start command, waits for a byte pattern, optionally decodes a
// decimal length up to ':' and reports a match, a length or a timeout.
// ----------------------------------------------------------------------------
// The block accepts one input transaction per clock cycle while s_ready is
// high and produces at most one result transaction per input. An accepted
// transaction sits in an input register, and its result is loaded from there
// into the output register, which drives m_valid; the state machine computes
// each result combinationally from the held transaction, which sets the
// sustained rate of one transaction per cycle while the result side keeps
// taking. The input register and the output register decouple the two
// channels: a new transaction is accepted while a finished result still
// waits, and back-pressure on the result channel only stalls the input once
// both registers are full. Configuration writes take effect on the next edge
// and are meant to be issued while the block is idle.
// ----------------------------------------------------------------------------
module response_pattern_waiter #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int MAX_FIELD_BYTES   = 15
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // Input channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_command,
    input  logic [7:0]                     s_rx_byte,

    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_outcome,
    output logic signed [15:0]             m_length_value,

    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [rpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Input register holding one accepted transaction.
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_cmd_reg;
    logic [7:0]  in_byte_reg;

    // Output register holding one finished result.
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_outcome_reg;
    logic [15:0] out_value_reg;

    logic             consume;
    rpw_pkg::cfg_t    cfg;
    rpw_pkg::result_t res;

    // The held transaction is processed whenever the output register is free
    // or is being emptied in this same cycle.
    assign consume = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || consume;

    rpw_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_wr_en),
        .index   (cfg_index),
        .wdata   (cfg_wdata),
        .cfg     (cfg)
    );

    rpw_engine #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .MAX_FIELD_BYTES   (MAX_FIELD_BYTES)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (consume),
        .command (in_cmd_reg),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // A new transaction enters when offered; otherwise the register empties
    // once its content has been processed.
    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    // Processing a transaction always replaces the output register, with a
    // result or with nothing; a taken result without replacement clears it.
    always_comb begin
        if (consume) begin
            out_valid_next = res.valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_command;
            in_byte_reg <= s_rx_byte;
        end
        if (consume && res.valid) begin
            out_outcome_reg <= res.outcome;
            out_value_reg   <= res.length_value;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_outcome      = out_outcome_reg;
    assign m_length_value = $signed(out_value_reg);

`ifndef SYNTHESIS
    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (!$past(out_valid_reg) && out_valid_reg) |-> $past(consume))
        else $error("result appeared without a processed transaction");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !consume)
        else $error("pending result would be overwritten");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !consume) |=> (in_valid_reg && $stable(in_cmd_reg)
                                        && $stable(in_byte_reg)))
        else $error("unprocessed transaction lost from input register");
`endif

endmodule

// ----- rtl/core/rpw_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpw_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module rpw_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [rpw_pkg::CFG_IDX_W-1:0]     index,
    input  logic [rpw_pkg::CFG_DATA_W-1:0]    wdata,
    output rpw_pkg::cfg_t                     cfg
);

    rpw_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern        <= {rpw_pkg::PATTERN_HIGH_RST, rpw_pkg::PATTERN_LOW_RST};
            cfg_reg.pattern_length <= rpw_pkg::PATTERN_LENGTH_RST;
            cfg_reg.length_mode    <= rpw_pkg::LENGTH_MODE_RST;
            cfg_reg.timeout_ticks  <= rpw_pkg::TIMEOUT_TICKS_RST;
        end else if (wr_en) begin
            case (index)
                rpw_pkg::REG_PATTERN_LOW:    cfg_reg.pattern[63:0]   <= wdata;
                rpw_pkg::REG_PATTERN_HIGH:   cfg_reg.pattern[127:64] <= wdata;
                rpw_pkg::REG_PATTERN_LENGTH: cfg_reg.pattern_length  <= wdata[4:0];
                rpw_pkg::REG_LENGTH_MODE:    cfg_reg.length_mode     <= wdata[0];
                rpw_pkg::REG_TIMEOUT_TICKS:  cfg_reg.timeout_ticks   <= wdata[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/rpw_num_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpw_num_parser
// One character step of the decimal length parser and its final value.
// ----------------------------------------------------------------------------
module rpw_num_parser (
    input  rpw_pkg::num_state_t cur,
    input  logic [7:0]          char_in,
    output rpw_pkg::num_state_t nxt,
    output logic [15:0]         value
);

    logic        is_space;
    logic        is_digit;
    logic        is_sign;
    logic [19:0] prod;
    logic [16:0] acc_digit;

    assign is_space = char_in inside {8'h20, [8'h09:8'h0D]};
    assign is_digit = char_in inside {[8'h30:8'h39]};
    assign is_sign  = (char_in == rpw_pkg::CHAR_PLUS) || (char_in == rpw_pkg::CHAR_MINUS);

    // acc * 10 + digit, saturated at the magnitude limit.
    assign prod = 20'({cur.acc, 3'b000}) + 20'({cur.acc, 1'b0}) + 20'(char_in[3:0]);
    assign acc_digit = (prod > 20'(rpw_pkg::MAG_LIMIT)) ? rpw_pkg::MAG_LIMIT : prod[16:0];

    always_comb begin
        nxt = cur;
        case (cur.stage)
            rpw_pkg::ST_SPACE: begin
                if (is_space) begin
                    nxt = cur;
                end else if (is_sign) begin
                    nxt.negative = (char_in == rpw_pkg::CHAR_MINUS);
                    nxt.stage    = rpw_pkg::ST_DIGITS;
                end else if (is_digit) begin
                    nxt.stage = rpw_pkg::ST_DIGITS;
                    nxt.acc   = acc_digit;
                end else begin
                    nxt.stage = rpw_pkg::ST_DONE;
                end
            end
            rpw_pkg::ST_DIGITS: begin
                if (is_digit) begin
                    nxt.acc = acc_digit;
                end else begin
                    nxt.stage = rpw_pkg::ST_DONE;
                end
            end
            default: nxt = cur;
        endcase
    end

    // The magnitude never exceeds the limit, so negation in 16 bits is exact.
    always_comb begin
        if (cur.negative) begin
            value = 16'd0 - cur.acc[15:0];
        end else if (cur.acc > 17'd32767) begin
            value = 16'h7FFF;
        end else begin
            value = cur.acc[15:0];
        end
    end

endmodule

// ----- rtl/core/rpw_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpw_engine
// Waiting state machine: pattern match, field collection and tick timeout.
// ----------------------------------------------------------------------------
module rpw_engine #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int MAX_FIELD_BYTES   = 15
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               go,
    input  logic [1:0]         command,
    input  logic [7:0]         rx_byte,
    input  rpw_pkg::cfg_t      cfg,
    output rpw_pkg::result_t   res
);

    localparam logic [4:0] MAX_PAT_LEN   = 5'(MAX_PATTERN_BYTES);
    localparam logic [3:0] MAX_FIELD_LEN = 4'(MAX_FIELD_BYTES);

    rpw_pkg::phase_t     phase_reg, phase_next;
    logic [4:0]          pos_reg, pos_next;
    logic [15:0]         tick_reg, tick_next;
    logic [3:0]          fcount_reg, fcount_next;
    rpw_pkg::num_state_t num_reg, num_next, num_step;

    logic [4:0]  used_len;
    logic [4:0]  pos_inc;
    logic [7:0]  pat_byte;
    logic [15:0] parsed_value;
    logic        start;
    logic        active;
    logic        is_byte;
    logic        is_tick;
    logic        match_hit;
    logic        match_full;
    logic        plain_done;
    logic        field_end;
    logic        timeout_hit;

    rpw_num_parser u_parser (
        .cur     (num_reg),
        .char_in (rx_byte),
        .nxt     (num_step),
        .value   (parsed_value)
    );

    always_comb begin
        if (cfg.pattern_length == 5'd0) begin
            used_len = 5'd1;
        end else if (cfg.pattern_length > MAX_PAT_LEN) begin
            used_len = MAX_PAT_LEN;
        end else begin
            used_len = cfg.pattern_length;
        end
    end

    assign pat_byte = cfg.pattern[{pos_reg[3:0], 3'b000} +: 8];
    assign pos_inc  = pos_reg + 5'd1;

    assign start      = go && (command == rpw_pkg::CMD_START);
    assign active     = go && (phase_reg != rpw_pkg::PH_IDLE)
                        && ((command == rpw_pkg::CMD_BYTE) || (command == rpw_pkg::CMD_TICK));
    assign is_byte    = active && (command == rpw_pkg::CMD_BYTE);
    assign is_tick    = active && (command == rpw_pkg::CMD_TICK);
    assign match_hit  = is_byte && (phase_reg == rpw_pkg::PH_MATCH) && (rx_byte == pat_byte);
    assign match_full = match_hit && (pos_inc >= used_len);
    assign plain_done = match_full && !cfg.length_mode;
    assign field_end  = is_byte && (phase_reg == rpw_pkg::PH_FIELD)
                        && (rx_byte == rpw_pkg::FIELD_END);
    assign tick_next  = start ? 16'd0 : (is_tick ? tick_reg + 16'd1 : tick_reg);
    assign timeout_hit = active && !plain_done && !field_end && (tick_next > cfg.timeout_ticks);

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            rpw_pkg::PH_IDLE: begin
                if (start) phase_next = rpw_pkg::PH_MATCH;
            end
            rpw_pkg::PH_MATCH: begin
                if (start) begin
                    phase_next = rpw_pkg::PH_MATCH;
                end else if (plain_done || timeout_hit) begin
                    phase_next = rpw_pkg::PH_IDLE;
                end else if (match_full) begin
                    phase_next = rpw_pkg::PH_FIELD;
                end
            end
            rpw_pkg::PH_FIELD: begin
                if (start) begin
                    phase_next = rpw_pkg::PH_MATCH;
                end else if (field_end || timeout_hit) begin
                    phase_next = rpw_pkg::PH_IDLE;
                end
            end
            default: phase_next = rpw_pkg::PH_IDLE;
        endcase
    end

    always_comb begin
        pos_next    = pos_reg;
        fcount_next = fcount_reg;
        num_next    = num_reg;
        if (start) begin
            pos_next       = 5'd0;
            fcount_next    = 4'd0;
            num_next.stage    = rpw_pkg::ST_SPACE;
            num_next.negative = 1'b0;
            num_next.acc      = 17'd0;
        end else if (is_byte && (phase_reg == rpw_pkg::PH_MATCH)) begin
            pos_next = match_hit ? pos_inc : 5'd0;
        end else if (is_byte && (phase_reg == rpw_pkg::PH_FIELD) && !field_end
                     && (fcount_reg < MAX_FIELD_LEN)) begin
            num_next    = num_step;
            fcount_next = fcount_reg + 4'd1;
        end
    end

    always_comb begin
        res.valid        = plain_done || field_end || timeout_hit;
        res.length_value = 16'd0;
        if (plain_done) begin
            res.outcome = rpw_pkg::OUT_MATCHED;
        end else if (field_end) begin
            res.outcome      = rpw_pkg::OUT_LENGTH;
            res.length_value = parsed_value;
        end else begin
            res.outcome = rpw_pkg::OUT_TIMEOUT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= rpw_pkg::PH_IDLE;
            pos_reg          <= 5'd0;
            tick_reg         <= 16'd0;
            fcount_reg       <= 4'd0;
            num_reg.stage    <= rpw_pkg::ST_SPACE;
            num_reg.negative <= 1'b0;
            num_reg.acc      <= 17'd0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            tick_reg   <= tick_next;
            fcount_reg <= fcount_next;
            num_reg    <= num_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MAX_PAT_LEN)
        else $error("match position beyond pattern size");

    a_field_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fcount_reg <= MAX_FIELD_LEN)
        else $error("field byte count beyond field size");

    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        num_reg.acc <= rpw_pkg::MAG_LIMIT)
        else $error("length accumulator beyond saturation limit");

    a_result_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (go && (phase_next == rpw_pkg::PH_IDLE)))
        else $error("result raised without an item or without disarming");
`endif

endmodule
